FILE: rtl/pec_pkg.sv
package pec_pkg;

    localparam int POS_W    = 16;
    localparam int HEAD_W   = 15;
    localparam int MARGIN_W = 13;
    localparam int COST_W   = 17;
    localparam int DIFF_W   = 17;
    localparam int ANG_W    = 19;
    localparam int VEC_W    = 19;
    localparam int SQ_W     = 34;
    localparam int NUM_W    = 36;
    localparam int ROOT_W   = 25;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int DIV_Q_W  = 18;
    localparam int DVD_W    = NUM_W + 8;
    localparam int AD_W     = 18;
    localparam int PEN_W    = 21;
    localparam int PENU_W   = 18;
    localparam int PART_W   = 22;
    localparam int SUM_W    = 23;

    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = DIV_Q_W;

    localparam logic signed [ANG_W-1:0] HEAD_PI_Q12  = 19'sd12868;
    localparam logic signed [ANG_W-1:0] HEAD_2PI_Q12 = 19'sd25736;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16  = 19'sd102944;
    localparam logic signed [ANG_W-1:0] PI_Q16       = 19'sd205888;
    localparam logic signed [VEC_W-1:0] CORDIC_START = 19'sd39797;
    localparam logic [MARGIN_W-1:0]     MARGIN_RESET = 13'd4;
    localparam logic [PEN_W-1:0]        ONE_Q16      = 21'd65536;
    localparam logic [SUM_W-1:0]        ROUND_HALF   = 23'd8;
    localparam logic [SUM_W-5:0]        COST_MAX     = 19'd81919;

    localparam logic [16:0] ATAN_Q16 [CORDIC_STEPS] = '{
        17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
        17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
    };

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } cordic_lane_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic                     flip_a;
        logic                     flip_b;
    } geo_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
    } sqrt_lane_t;

    typedef struct packed {
        logic [ROOT_W:0]    rem;
        logic [DIV_Q_W-1:0] low;
        logic [DIV_Q_W-1:0] quo;
        logic [ROOT_W-1:0]  den;
    } div_lane_t;

    typedef struct packed {
        logic            neg;
        logic [AD_W-1:0] ad;
    } div_side_t;

endpackage

FILE: rtl/pose_edge_cost.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     from_x, from_y, from_heading, to_x, to_y, to_heading
// output    out_valid / out_ready   edge_cost
// config    cfg_write               cfg_data (align_margin)
//
// One item enters per cycle while the skid register is empty; each accepted item passes
// through 16 CORDIC cells, 25 square-root cells, 18 divider cells and seven
// single-register stages before its result is offered.
// Reset clears every valid bit and loads align_margin with its default.
// A stalled output fills a one-item skid register; while it is full the chain holds.
module pose_edge_cost
    import pec_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [MARGIN_W-1:0]      cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [POS_W-1:0]         from_x,
    input  logic [POS_W-1:0]         from_y,
    input  logic signed [HEAD_W-1:0] from_heading,
    input  logic [POS_W-1:0]         to_x,
    input  logic [POS_W-1:0]         to_y,
    input  logic signed [HEAD_W-1:0] to_heading,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [COST_W-1:0]        edge_cost
);

    localparam int GEO_W  = $bits(geo_t);
    localparam int DSIDE_W = $bits(div_side_t);

    logic [MARGIN_W-1:0] margin_val_reg;
    logic                en;

    // front stage
    logic         a_valid_reg;
    cordic_lane_t a_lane_a_reg;
    cordic_lane_t a_lane_b_reg;
    geo_t         a_geo_reg;
    logic [ANG_W:0] prep_a;
    logic [ANG_W:0] prep_b;

    // CORDIC chain
    logic              cv   [CORDIC_STEPS+1];
    cordic_lane_t      cla  [CORDIC_STEPS+1];
    cordic_lane_t      clb  [CORDIC_STEPS+1];
    logic [GEO_W-1:0]  cside[CORDIC_STEPS+1];
    geo_t              geo_end;

    // product stages
    logic                    c_valid_reg;
    logic signed [VEC_W-1:0] c_c1_reg, c_s1_reg, c_c2_reg, c_s2_reg;
    logic signed [DIFF_W-1:0] c_dx_reg, c_dy_reg;
    logic signed [SQ_W-1:0]  c_dx2_reg, c_dy2_reg;

    logic                     d_valid_reg;
    logic [SQ_W-1:0]          d_sq_reg;
    logic signed [VEC_W:0]    d_dc_reg, d_ds_reg;
    logic signed [NUM_W-1:0]  d_p1_reg, d_p2_reg;
    logic [SQ_W:0]            d_sq_sum;

    logic                     e_valid_reg;
    logic [SQ_W-1:0]          e_sq_reg;
    logic signed [NUM_W-1:0]  e_num_reg;
    logic [2*VEC_W+1:0]       e_dc2_reg, e_ds2_reg;

    logic                     f_valid_reg;
    logic [RAD_W-1:0]         f_den_rad_reg;
    logic [RAD_W-1:0]         f_ad_rad_reg;
    logic signed [NUM_W-1:0]  f_num_reg;
    logic [2*VEC_W+2:0]       e_ad_sum;

    // square-root chain
    logic              sv   [ROOT_W+1];
    sqrt_lane_t        sla  [ROOT_W+1];
    sqrt_lane_t        slb  [ROOT_W+1];
    logic [NUM_W-1:0]  sside[ROOT_W+1];

    // divider chain
    logic                dv   [DIV_STEPS+1];
    div_lane_t           dl   [DIV_STEPS+1];
    logic [DSIDE_W-1:0]  dside[DIV_STEPS+1];
    logic [NUM_W-1:0]    num_mag;
    logic [DVD_W-1:0]    dvd;
    div_side_t           dside_in;
    div_side_t           dside_end;

    // final stages
    logic                     g_valid_reg;
    logic [PENU_W-1:0]        g_pen_reg;
    logic [PART_W-1:0]        g_part_reg;
    logic signed [DIV_Q_W+1:0] dot;
    logic [PEN_W-1:0]         pen_w;
    logic [SUM_W-1:0]         sum_w;
    logic [SUM_W-5:0]         rnd;
    logic [COST_W-1:0]        cost;

    logic                out_valid_reg;
    logic [COST_W-1:0]   out_cost_reg;
    logic                skid_full_reg;
    logic [COST_W-1:0]   skid_cost_reg;
    logic                take;
    logic                push;

    function automatic logic [ANG_W:0] head_prep(input logic signed [HEAD_W-1:0] h);
        logic signed [ANG_W-1:0] hw;
        logic signed [ANG_W-1:0] z;
        logic                    flip;
        hw   = {{(ANG_W-HEAD_W){h[HEAD_W-1]}}, h};
        flip = 1'b0;
        if (hw > HEAD_PI_Q12)
        begin
            hw = hw - HEAD_2PI_Q12;
        end
        else if (hw < -HEAD_PI_Q12)
        begin
            hw = hw + HEAD_2PI_Q12;
        end
        z = hw <<< 4;
        if (z > HALF_PI_Q16)
        begin
            z    = z - PI_Q16;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q16)
        begin
            z    = z + PI_Q16;
            flip = 1'b1;
        end
        return {flip, z};
    endfunction

    assign en       = !skid_full_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_val_reg <= MARGIN_RESET;
        end
        else if (cfg_write)
        begin
            margin_val_reg <= cfg_data;
        end
    end

    assign prep_a = head_prep(from_heading);
    assign prep_b = head_prep(to_heading);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            c_valid_reg <= cv[CORDIC_STEPS];
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= dv[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_lane_a_reg     <= '{x: CORDIC_START, y: '0, z: signed'(prep_a[ANG_W-1:0])};
            a_lane_b_reg     <= '{x: CORDIC_START, y: '0, z: signed'(prep_b[ANG_W-1:0])};
            a_geo_reg.dx     <= signed'({1'b0, to_x}) - signed'({1'b0, from_x});
            a_geo_reg.dy     <= signed'({1'b0, to_y}) - signed'({1'b0, from_y});
            a_geo_reg.flip_a <= prep_a[ANG_W];
            a_geo_reg.flip_b <= prep_b[ANG_W];
        end
    end

    assign cv[0]    = a_valid_reg;
    assign cla[0]   = a_lane_a_reg;
    assign clb[0]   = a_lane_b_reg;
    assign cside[0] = a_geo_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        pec_cordic_cell #(
            .STEP   (i),
            .SIDE_W (GEO_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .valid_in   (cv[i]),
            .lane_a_in  (cla[i]),
            .lane_b_in  (clb[i]),
            .side_in    (cside[i]),
            .valid_out  (cv[i+1]),
            .lane_a_out (cla[i+1]),
            .lane_b_out (clb[i+1]),
            .side_out   (cside[i+1])
        );
    end

    assign geo_end  = geo_t'(cside[CORDIC_STEPS]);
    assign d_sq_sum = {1'b0, c_dx2_reg} + {1'b0, c_dy2_reg};
    assign e_ad_sum = {1'b0, e_dc2_reg} + {1'b0, e_ds2_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // unit vectors, flipped back into the correct half plane
            c_c1_reg  <= geo_end.flip_a ? -cla[CORDIC_STEPS].x : cla[CORDIC_STEPS].x;
            c_s1_reg  <= geo_end.flip_a ? -cla[CORDIC_STEPS].y : cla[CORDIC_STEPS].y;
            c_c2_reg  <= geo_end.flip_b ? -clb[CORDIC_STEPS].x : clb[CORDIC_STEPS].x;
            c_s2_reg  <= geo_end.flip_b ? -clb[CORDIC_STEPS].y : clb[CORDIC_STEPS].y;
            c_dx_reg  <= geo_end.dx;
            c_dy_reg  <= geo_end.dy;
            c_dx2_reg <= geo_end.dx * geo_end.dx;
            c_dy2_reg <= geo_end.dy * geo_end.dy;

            d_sq_reg  <= d_sq_sum[SQ_W-1:0];
            d_dc_reg  <= {c_c1_reg[VEC_W-1], c_c1_reg} - {c_c2_reg[VEC_W-1], c_c2_reg};
            d_ds_reg  <= {c_s1_reg[VEC_W-1], c_s1_reg} - {c_s2_reg[VEC_W-1], c_s2_reg};
            d_p1_reg  <= c_c1_reg * c_dx_reg;
            d_p2_reg  <= c_s1_reg * c_dy_reg;

            e_sq_reg  <= d_sq_reg;
            e_num_reg <= d_p1_reg + d_p2_reg;
            e_dc2_reg <= d_dc_reg * d_dc_reg;
            e_ds2_reg <= d_ds_reg * d_ds_reg;

            f_den_rad_reg <= {e_sq_reg, 16'b0};
            f_ad_rad_reg  <= {{(RAD_W-2*VEC_W-3){1'b0}}, e_ad_sum};
            f_num_reg     <= e_num_reg;
        end
    end

    assign sv[0]    = f_valid_reg;
    assign sla[0]   = '{rad: f_den_rad_reg, rem: '0, root: '0};
    assign slb[0]   = '{rad: f_ad_rad_reg, rem: '0, root: '0};
    assign sside[0] = f_num_reg;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        pec_sqrt_cell #(
            .SIDE_W (NUM_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .valid_in   (sv[i]),
            .lane_a_in  (sla[i]),
            .lane_b_in  (slb[i]),
            .side_in    (sside[i]),
            .valid_out  (sv[i+1]),
            .lane_a_out (sla[i+1]),
            .lane_b_out (slb[i+1]),
            .side_out   (sside[i+1])
        );
    end

    assign num_mag      = sside[ROOT_W][NUM_W-1] ? -sside[ROOT_W] : sside[ROOT_W];
    assign dvd          = {num_mag, 8'b0};
    assign dside_in.neg = sside[ROOT_W][NUM_W-1];
    assign dside_in.ad  = slb[ROOT_W].root[AD_W-1:0];

    assign dv[0]    = sv[ROOT_W];
    assign dl[0]    = '{rem: dvd[DVD_W-1 -: ROOT_W+1], low: dvd[DIV_Q_W-1:0],
                        quo: '0, den: sla[ROOT_W].root};
    assign dside[0] = dside_in;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        pec_div_cell #(
            .SIDE_W (DSIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv[i]),
            .lane_in   (dl[i]),
            .side_in   (dside[i]),
            .valid_out (dv[i+1]),
            .lane_out  (dl[i+1]),
            .side_out  (dside[i+1])
        );
    end

    assign dside_end = div_side_t'(dside[DIV_STEPS]);

    always_comb
    begin
        // coincident positions give a zero divisor: drop the alignment term
        if (dl[DIV_STEPS].den == '0)
        begin
            dot = '0;
        end
        else if (dside_end.neg)
        begin
            dot = -signed'({2'b00, dl[DIV_STEPS].quo});
        end
        else
        begin
            dot = signed'({2'b00, dl[DIV_STEPS].quo});
        end
        pen_w = ONE_Q16 - {{(PEN_W-DIV_Q_W-2){dot[DIV_Q_W+1]}}, dot}
              - {{(PEN_W-MARGIN_W-4){1'b0}}, margin_val_reg, 4'b0000};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_pen_reg  <= pen_w[PEN_W-1] ? '0 : pen_w[PENU_W-1:0];
            g_part_reg <= {1'b0, dl[DIV_STEPS].den[ROOT_W-1:8], 4'b0000}
                        + {{(PART_W-AD_W){1'b0}}, dside_end.ad};
        end
    end

    assign sum_w = {1'b0, g_part_reg} + {{(SUM_W-PENU_W){1'b0}}, g_pen_reg} + ROUND_HALF;
    assign rnd   = sum_w[SUM_W-1:4];
    assign cost  = (rnd > COST_MAX) ? COST_MAX[COST_W-1:0] : rnd[COST_W-1:0];

    assign take = out_valid_reg && out_ready;
    assign push = en && g_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (take)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_full_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (take)
            begin
                out_cost_reg <= skid_cost_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_cost_reg <= cost;
            end
            else
            begin
                out_cost_reg <= cost;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign edge_cost = out_cost_reg;

endmodule

FILE: rtl/pec_cordic_cell.sv
module pec_cordic_cell
    import pec_pkg::*;
#(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  cordic_lane_t      lane_a_in,
    input  cordic_lane_t      lane_b_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output cordic_lane_t      lane_a_out,
    output cordic_lane_t      lane_b_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg;
    cordic_lane_t      lane_a_reg;
    cordic_lane_t      lane_b_reg;
    logic [SIDE_W-1:0] side_reg;
    cordic_lane_t      lane_a_next;
    cordic_lane_t      lane_b_next;

    function automatic cordic_lane_t rotate(input cordic_lane_t l);
        cordic_lane_t            r;
        logic signed [ANG_W-1:0] a;
        a = signed'({2'b00, ATAN_Q16[STEP]});
        if (l.z >= 0)
        begin
            r.x = l.x - (l.y >>> STEP);
            r.y = l.y + (l.x >>> STEP);
            r.z = l.z - a;
        end
        else
        begin
            r.x = l.x + (l.y >>> STEP);
            r.y = l.y - (l.x >>> STEP);
            r.z = l.z + a;
        end
        return r;
    endfunction

    always_comb
    begin
        lane_a_next = rotate(lane_a_in);
        lane_b_next = rotate(lane_b_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_b_next;
            side_reg   <= side_in;
        end
    end

    assign valid_out  = valid_reg;
    assign lane_a_out = lane_a_reg;
    assign lane_b_out = lane_b_reg;
    assign side_out   = side_reg;

endmodule

FILE: rtl/pec_sqrt_cell.sv
module pec_sqrt_cell
    import pec_pkg::*;
#(
    parameter int SIDE_W = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  sqrt_lane_t        lane_a_in,
    input  sqrt_lane_t        lane_b_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output sqrt_lane_t        lane_a_out,
    output sqrt_lane_t        lane_b_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg;
    sqrt_lane_t        lane_a_reg;
    sqrt_lane_t        lane_b_reg;
    logic [SIDE_W-1:0] side_reg;
    sqrt_lane_t        lane_a_next;
    sqrt_lane_t        lane_b_next;

    function automatic sqrt_lane_t digit(input sqrt_lane_t l);
        sqrt_lane_t        r;
        logic [ROOT_W+1:0] rem2;
        logic [ROOT_W+1:0] trial;
        rem2  = {l.rem[ROOT_W-1:0], l.rad[RAD_W-1 -: 2]};
        trial = {l.root, 2'b01};
        r.rad = {l.rad[RAD_W-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            r.rem  = rem2 - trial;
            r.root = {l.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2;
            r.root = {l.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        lane_a_next = digit(lane_a_in);
        lane_b_next = digit(lane_b_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_b_next;
            side_reg   <= side_in;
        end
    end

    assign valid_out  = valid_reg;
    assign lane_a_out = lane_a_reg;
    assign lane_b_out = lane_b_reg;
    assign side_out   = side_reg;

endmodule

FILE: rtl/pec_div_cell.sv
module pec_div_cell
    import pec_pkg::*;
#(
    parameter int SIDE_W = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  div_lane_t         lane_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output div_lane_t         lane_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg;
    div_lane_t         lane_reg;
    logic [SIDE_W-1:0] side_reg;
    div_lane_t         lane_next;
    logic [ROOT_W:0]   rem2;

    always_comb
    begin
        rem2          = {lane_in.rem[ROOT_W-1:0], lane_in.low[DIV_Q_W-1]};
        lane_next.den = lane_in.den;
        lane_next.low = {lane_in.low[DIV_Q_W-2:0], 1'b0};
        if (rem2 >= {1'b0, lane_in.den})
        begin
            lane_next.rem = rem2 - {1'b0, lane_in.den};
            lane_next.quo = {lane_in.quo[DIV_Q_W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem = rem2;
            lane_next.quo = {lane_in.quo[DIV_Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;
    assign side_out  = side_reg;

endmodule

FILE: tb/sv/pose_edge_cost_chk.sv
module pose_edge_cost_chk
    import pec_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [MARGIN_W-1:0]      cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [POS_W-1:0]         from_x,
    input  logic [POS_W-1:0]         from_y,
    input  logic signed [HEAD_W-1:0] from_heading,
    input  logic [POS_W-1:0]         to_x,
    input  logic [POS_W-1:0]         to_y,
    input  logic signed [HEAD_W-1:0] to_heading,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [COST_W-1:0]        edge_cost,
    output int                       fail_count,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [MARGIN_W-1:0] margin_q;
    logic [COST_W-1:0]   cost_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    task automatic heading_vec(input longint h, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        x = CORDIC_START;
        y = 0;
        flip = 0;
        if (h > HEAD_PI_Q12)
            h -= HEAD_2PI_Q12;
        else if (h < -HEAD_PI_Q12)
            h += HEAD_2PI_Q12;
        z = h * 16;
        if (z > HALF_PI_Q16)
        begin
            z -= PI_Q16;
            flip = 1;
        end
        else if (z < -HALF_PI_Q16)
        begin
            z += PI_Q16;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fshift(y, i);
                y = y + fshift(x, i);
                z -= longint'(ATAN_Q16[i]);
            end
            else
            begin
                nx = x + fshift(y, i);
                y = y - fshift(x, i);
                z += longint'(ATAN_Q16[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_cost(output logic [COST_W-1:0] cost);
        longint dx;
        longint dy;
        longint sq;
        longint pd;
        longint c1;
        longint s1;
        longint c2;
        longint s2;
        longint ad;
        longint dot;
        longint pen;
        longint total;
        longint den;
        dx = longint'(to_x) - longint'(from_x);
        dy = longint'(to_y) - longint'(from_y);
        sq = dx * dx + dy * dy;
        pd = int_sqrt(sq);
        heading_vec(longint'(from_heading), c1, s1);
        heading_vec(longint'(to_heading), c2, s2);
        ad = int_sqrt((c1 - c2) * (c1 - c2) + (s1 - s2) * (s1 - s2));
        dot = 0;
        if (sq != 0)
        begin
            den = int_sqrt(sq << 16);
            dot = ((c1 * dx + s1 * dy) * 256) / den;
        end
        pen = 65536 - dot - 16 * longint'(margin_q);
        if (pen < 0)
            pen = 0;
        total = (16 * pd + ad + pen + 8) >>> 4;
        if (total > COST_MAX)
            total = COST_MAX;
        cost = total[COST_W-1:0];
    endtask

    assign pending = cost_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [COST_W-1:0] want;
        if (!rst_n)
        begin
            margin_q <= MARGIN_RESET;
            cost_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_write)
                margin_q <= cfg_data;
            if (in_valid && in_ready)
            begin
                predict_cost(want);
                cost_q.insert(cost_q.size(), want);
            end
            if (out_valid && out_ready)
            begin
                if (cost_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected edge_cost %0d", edge_cost);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = cost_q.pop_front();
                    if (edge_cost !== want)
                    begin
                        if (fail_count < 10)
                            $display("edge_cost mismatch: expected %0d, got %0d",
                                     want, edge_cost);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/sv/pose_edge_cost_tb.sv
module pose_edge_cost_tb;
    import pec_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 66;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [MARGIN_W-1:0]      cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [POS_W-1:0]         from_x;
    logic [POS_W-1:0]         from_y;
    logic signed [HEAD_W-1:0] from_heading;
    logic [POS_W-1:0]         to_x;
    logic [POS_W-1:0]         to_y;
    logic signed [HEAD_W-1:0] to_heading;
    logic                     out_valid;
    logic                     out_ready;
    logic [COST_W-1:0]        edge_cost;
    int                       fail_count;
    int                       pending;
    bit                       stim_done;

    pose_edge_cost u_dut (.*);
    pose_edge_cost_chk u_chk (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return POS_W'($urandom());
        if (r == 1)
            return $urandom_range(0, 1) ? 16'd0 : 16'd40960;
        return POS_W'($urandom_range(0, 40960));
    endfunction

    function automatic logic signed [HEAD_W-1:0] rand_head();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return HEAD_W'($urandom());
        if (r == 1)
            return $urandom_range(0, 1) ? -15'sd12868 : 15'sd12868;
        return HEAD_W'(int'($urandom_range(0, 25736)) - 12868);
    endfunction

    task automatic send_edge(input logic [POS_W-1:0] fx, input logic [POS_W-1:0] fy,
                             input logic signed [HEAD_W-1:0] fh,
                             input logic [POS_W-1:0] tx, input logic [POS_W-1:0] ty,
                             input logic signed [HEAD_W-1:0] th);
        int g;
        g = gap_len();
        repeat (g)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid     <= 1;
        from_x       <= fx;
        from_y       <= fy;
        from_heading <= fh;
        to_x         <= tx;
        to_y         <= ty;
        to_heading   <= th;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_margin(input logic [MARGIN_W-1:0] m);
        in_valid <= 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_write <= 1;
        cfg_data  <= m;
        @(negedge clk);
        cfg_write <= 0;
    endtask

    task automatic random_edges(input int n);
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        for (int i = 0; i < n; i++)
        begin
            px = rand_pos();
            py = rand_pos();
            if ($urandom_range(0, 19) == 0)
                send_edge(px, py, rand_head(), px, py, rand_head());
            else
                send_edge(px, py, rand_head(), rand_pos(), rand_pos(), rand_head());
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_write = 0;
        cfg_data = 0;
        in_valid = 0;
        from_x = 0;
        from_y = 0;
        from_heading = 0;
        to_x = 0;
        to_y = 0;
        to_heading = 0;
        stim_done = 0;
        repeat (3) @(negedge clk);
        rst_n = 1;
        send_edge(0, 0, 0, 0, 0, 0);
        send_edge(0, 0, 15'sd12868, 16'd40960, 16'd40960, -15'sd12868);
        send_edge(16'd40960, 16'd40960, -15'sd12868, 0, 0, 15'sd12868);
        send_edge(16'hFFFF, 16'hFFFF, 15'sh3FFF, 0, 0, -15'sh4000);
        send_edge(0, 0, -15'sh4000, 16'hFFFF, 16'hFFFF, 15'sh3FFF);
        send_edge(16'd20480, 16'd20480, 15'sd6434, 16'd20480, 16'd20480, -15'sd6434);
        send_edge(0, 16'd4096, 0, 16'd8192, 16'd4096, 0);
        send_edge(16'd8192, 0, 0, 0, 0, 15'sd12868);
        send_edge(0, 0, 15'sd6434, 0, 16'd40960, 15'sd6434);
        send_edge(16'd100, 16'd100, 15'sd13000, 16'd101, 16'd100, -15'sd13000);
        send_edge(16'h5555, 16'hAAAA, 15'sh2AAA, 16'hAAAA, 16'h5555, -15'sh2AAB);
        random_edges(300);
        set_margin(13'd0);
        send_edge(0, 0, 0, 16'd4096, 0, 0);
        random_edges(300);
        set_margin(13'd4096);
        send_edge(0, 0, 0, 0, 0, 0);
        random_edges(250);
        set_margin(13'h1FFF);
        random_edges(200);
        set_margin(13'h0AAA);
        random_edges(150);
        set_margin(13'h1555);
        random_edges(150);
        in_valid <= 0;
        stim_done = 1;
    end

    initial
    begin
        int g;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                out_ready <= 0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("pose_edge_cost_tb passed");
        else
            $display("pose_edge_cost_tb failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("pose_edge_cost_tb failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/pec_pkg.sv
rtl/pec_cordic_cell.sv
rtl/pec_sqrt_cell.sv
rtl/pec_div_cell.sv
rtl/pose_edge_cost.sv
tb/sv/pose_edge_cost_chk.sv
tb/sv/pose_edge_cost_tb.sv
